[design/ept_pkg.sv]
// ---------------------------------------------------------------------------
// Edge pair count table package
// Shared payload types and codes for the edge pair count table.
// ---------------------------------------------------------------------------
`default_nettype none
package ept_pkg;

  // Operation codes of a request.
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Status codes of a result.
  localparam logic [1:0] ST_RECORDED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_CLEARED  = 2'd2;

  // Saturation value of a pair count.
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Request payload.
  typedef struct packed {
    logic        operation;
    logic [63:0] source_address;
    logic [63:0] target_address;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [31:0] hit_count;
    logic        newly_added;
    logic [12:0] entries_held;
    logic [10:0] buckets_occupied;
    logic [1:0]  status;
  } rsp_t;

endpackage
`default_nettype wire

[design/ept_front.sv]
// ---------------------------------------------------------------------------
// Edge pair count table front end
// Accepts requests, masks the addresses and computes the bucket index.
// ---------------------------------------------------------------------------
`default_nettype none
module ept_front
  import ept_pkg::*;
#(
  parameter int BUCKET_COUNT = 1024,
  parameter int ADDRESS_BITS = 64,
  localparam int IDX_W = $clog2(BUCKET_COUNT),
  localparam int WIDTH = 1 + IDX_W + 2 * ADDRESS_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire req_t             req,
  output logic                  item_valid,
  input  wire logic             item_ready,
  output logic [WIDTH-1:0]      item
);

  localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDRESS_BITS);

  logic [63:0]      src_m;
  logic [63:0]      dst_m;
  logic [63:0]      hash;
  logic [WIDTH-1:0] item_next;

  // Classify the request: masked addresses and bucket index.
  always_comb begin
    src_m     = req.source_address & ADDR_MASK;
    dst_m     = req.target_address & ADDR_MASK;
    hash      = src_m ^ dst_m;
    item_next = {req.operation, hash[IDX_W-1:0], src_m[ADDRESS_BITS-1:0],
                 dst_m[ADDRESS_BITS-1:0]};
  end

  assign req_ready = !item_valid || item_ready;

  // Holding register toward the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_ready) begin
      item_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

[design/ept_queue.sv]
// ---------------------------------------------------------------------------
// Edge pair count table queue
// Two-entry queue that decouples the front end from the table sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
module ept_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[design/ept_back.sv]
// ---------------------------------------------------------------------------
// Edge pair count table sequencer
// Walks bucket chains in the table memories and produces one result per item.
// ---------------------------------------------------------------------------
`default_nettype none
module ept_back
  import ept_pkg::*;
#(
  parameter int BUCKET_COUNT = 1024,
  parameter int POOL_ENTRIES = 4096,
  parameter int ADDRESS_BITS = 64,
  localparam int IDX_W = $clog2(BUCKET_COUNT),
  localparam int WIDTH = 1 + IDX_W + 2 * ADDRESS_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire logic [WIDTH-1:0] item,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output rsp_t                  rsp
);

  localparam int EW   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int PTR_W = $clog2(POOL_ENTRIES + 1);
  localparam int BT_W = $clog2(BUCKET_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_BUCKET = IDX_W'(BUCKET_COUNT - 1);
  localparam logic [PTR_W-1:0] POOL_LIMIT = PTR_W'(POOL_ENTRIES);

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_HEAD, S_ENTRY, S_ALLOC, S_LINK
  } state_t;

  // Memories: bucket heads and entry fields.
  logic [EW:0]             bkt_mem [BUCKET_COUNT];
  logic [ADDRESS_BITS-1:0] src_mem [POOL_ENTRIES];
  logic [ADDRESS_BITS-1:0] dst_mem [POOL_ENTRIES];
  logic [31:0]             cnt_mem [POOL_ENTRIES];
  logic [EW:0]             lnk_mem [POOL_ENTRIES];

  logic [EW:0]             bkt_rd;
  logic [ADDRESS_BITS-1:0] src_rd;
  logic [ADDRESS_BITS-1:0] dst_rd;
  logic [31:0]             cnt_rd;
  logic [EW:0]             lnk_rd;

  state_t                  state;
  logic [IDX_W-1:0]        sweep_idx;
  logic [PTR_W-1:0]        pool_free;
  logic [PTR_W-1:0]        pair_tally;
  logic [BT_W-1:0]         bucket_tally;
  logic [IDX_W-1:0]        cur_idx;
  logic [ADDRESS_BITS-1:0] cur_src;
  logic [ADDRESS_BITS-1:0] cur_dst;
  logic [EW-1:0]           cur_ptr;
  logic [EW-1:0]           last_ptr;
  logic [EW-1:0]           fresh_ptr;
  logic                    has_tail;

  logic                    it_op;
  logic [IDX_W-1:0]        it_idx;
  logic [ADDRESS_BITS-1:0] it_src;
  logic [ADDRESS_BITS-1:0] it_dst;

  logic                    bkt_we;
  logic [IDX_W-1:0]        bkt_waddr;
  logic [EW:0]             bkt_wdata;
  logic [IDX_W-1:0]        bkt_raddr;
  logic                    ent_we;
  logic                    cnt_we;
  logic [EW-1:0]           cnt_waddr;
  logic [31:0]             cnt_wdata;
  logic                    lnk_we;
  logic [EW-1:0]           lnk_waddr;
  logic [EW:0]             lnk_wdata;
  logic [EW-1:0]           ent_raddr;
  logic                    match;
  logic [31:0]             cnt_inc;
  logic [EW-1:0]           fresh;
  logic                    pool_full;
  logic [PTR_W-1:0]        pair_inc;
  logic [BT_W-1:0]         bucket_inc;
  logic [PTR_W+12:0]       pair_ext;
  logic [BT_W+10:0]        bucket_ext;
  logic [PTR_W+12:0]       pair_inc_ext;
  logic [BT_W+10:0]        bucket_inc_ext;

  assign {it_op, it_idx, it_src, it_dst} = item;
  assign item_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);

  // Compare, count update and allocation values.
  always_comb begin
    match          = (src_rd == cur_src) && (dst_rd == cur_dst);
    cnt_inc        = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 32'd1;
    fresh          = pool_free[EW-1:0];
    pool_full      = (pool_free >= POOL_LIMIT);
    pair_inc       = pair_tally + PTR_W'(1);
    bucket_inc     = has_tail ? bucket_tally : bucket_tally + BT_W'(1);
    pair_ext       = {13'd0, pair_tally};
    bucket_ext     = {11'd0, bucket_tally};
    pair_inc_ext   = {13'd0, pair_inc};
    bucket_inc_ext = {11'd0, bucket_inc};
  end

  // Memory port control.
  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = sweep_idx;
    bkt_wdata = {1'b0, fresh};
    bkt_raddr = cur_idx;
    ent_we    = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = cur_ptr;
    cnt_wdata = cnt_inc;
    lnk_we    = 1'b0;
    lnk_waddr = fresh;
    lnk_wdata = {1'b0, fresh};
    ent_raddr = lnk_rd[EW-1:0];
    case (state)
      S_SWEEP: begin
        bkt_we = 1'b1;
      end
      S_IDLE: begin
        bkt_raddr = it_idx;
      end
      S_HEAD: begin
        ent_raddr = bkt_rd[EW-1:0];
      end
      S_ENTRY: begin
        cnt_we = match;
      end
      S_ALLOC: begin
        if (!pool_full) begin
          ent_we    = 1'b1;
          cnt_we    = 1'b1;
          cnt_waddr = fresh;
          cnt_wdata = 32'd1;
          lnk_we    = 1'b1;
          bkt_we    = !has_tail;
          bkt_waddr = cur_idx;
          bkt_wdata = {1'b1, fresh};
        end
      end
      S_LINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = last_ptr;
        lnk_wdata = {1'b1, fresh_ptr};
      end
      default: begin
      end
    endcase
  end

  // Bucket head memory.
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rd <= bkt_mem[bkt_raddr];
  end

  // Entry memories.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      src_mem[fresh] <= cur_src;
      dst_mem[fresh] <= cur_dst;
    end
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    src_rd <= src_mem[ent_raddr];
    dst_rd <= dst_mem[ent_raddr];
    cnt_rd <= cnt_mem[ent_raddr];
    lnk_rd <= lnk_mem[ent_raddr];
  end

  // Sequencer state and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep_idx    <= '0;
      pool_free    <= '0;
      pair_tally   <= '0;
      bucket_tally <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sweep_idx <= sweep_idx + IDX_W'(1);
          if (sweep_idx == LAST_BUCKET) begin
            sweep_idx <= '0;
            state     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid && item_ready) begin
            cur_idx  <= it_idx;
            cur_src  <= it_src;
            cur_dst  <= it_dst;
            has_tail <= 1'b0;
            if (it_op == OP_CLEAR) begin
              pool_free    <= '0;
              pair_tally   <= '0;
              bucket_tally <= '0;
              rsp_valid    <= 1'b1;
              rsp          <= '{hit_count: 32'd0, newly_added: 1'b0,
                                entries_held: 13'd0, buckets_occupied: 11'd0,
                                status: ST_CLEARED};
              state        <= S_SWEEP;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          cur_ptr <= bkt_rd[EW-1:0];
          state   <= bkt_rd[EW] ? S_ENTRY : S_ALLOC;
        end
        S_ENTRY: begin
          if (match) begin
            rsp_valid <= 1'b1;
            rsp       <= '{hit_count: cnt_inc, newly_added: 1'b0,
                           entries_held: pair_ext[12:0],
                           buckets_occupied: bucket_ext[10:0],
                           status: ST_RECORDED};
            state     <= S_IDLE;
          end else begin
            last_ptr <= cur_ptr;
            has_tail <= 1'b1;
            if (lnk_rd[EW]) begin
              cur_ptr <= lnk_rd[EW-1:0];
            end else begin
              state <= S_ALLOC;
            end
          end
        end
        S_ALLOC: begin
          rsp_valid <= 1'b1;
          if (pool_full) begin
            rsp   <= '{hit_count: 32'd0, newly_added: 1'b0,
                       entries_held: pair_ext[12:0],
                       buckets_occupied: bucket_ext[10:0],
                       status: ST_DROPPED};
            state <= S_IDLE;
          end else begin
            pool_free    <= pool_free + PTR_W'(1);
            pair_tally   <= pair_inc;
            bucket_tally <= bucket_inc;
            fresh_ptr    <= fresh;
            rsp          <= '{hit_count: 32'd1, newly_added: 1'b1,
                              entries_held: pair_inc_ext[12:0],
                              buckets_occupied: bucket_inc_ext[10:0],
                              status: ST_RECORDED};
            state        <= has_tail ? S_LINK : S_IDLE;
          end
        end
        S_LINK: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/edge_pair_count_table_unit.sv]
// ---------------------------------------------------------------------------
// Edge pair count table unit
// Counts source and target address pairs in a chained hash table.
// ---------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------
//  request | req_valid, req_ready  | req  (operation, addresses)
//  result  | rsp_valid, rsp_ready  | rsp  (count, tallies, status)
//
// A record item reads the bucket head and then one chain entry per step,
// until a match or the end of the chain. A miss adds an allocate step, and
// a link step for a new entry on a non-empty chain. The single read port of
// the entry memories sets this pace.
// A clear item sets its result and then starts a pass over all BUCKET_COUNT
// buckets of the bucket memory, one bucket a cycle. The same pass runs
// after reset before any item starts.
// Requests are taken into the two-entry queue while the sequencer is busy or
// a result waits for rsp_ready, until the queue is full.
`default_nettype none
module edge_pair_count_table_unit
  import ept_pkg::*;
#(
  parameter int BUCKET_COUNT = 1024,
  parameter int POOL_ENTRIES = 4096,
  parameter int ADDRESS_BITS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int IDX_W = $clog2(BUCKET_COUNT);
  localparam int WIDTH = 1 + IDX_W + 2 * ADDRESS_BITS;

  logic             f_valid;
  logic             f_ready;
  logic [WIDTH-1:0] f_item;
  logic             q_valid;
  logic             q_ready;
  logic [WIDTH-1:0] q_item;

  // Front end: classify requests.
  ept_front #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .item_valid(f_valid),
    .item_ready(f_ready),
    .item      (f_item)
  );

  // Queue between front end and sequencer.
  ept_queue #(
    .WIDTH(WIDTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data (f_item),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (q_item)
  );

  // Sequencer: table walk and result.
  ept_back #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .POOL_ENTRIES(POOL_ENTRIES),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(q_valid),
    .item_ready(q_ready),
    .item      (q_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
